@@ hdl/iibq_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// iibq_pkg: shared definitions for the integral image box query block
// Field widths, function codes, register indexes, datapath widths and the
// default sizes of the summed area table.
// ----------------------------------------------------------------------------
package iibq_pkg;

  // Default table geometry and pixel depth.
  localparam int DEF_MAX_ROWS   = 256;
  localparam int DEF_MAX_COLS   = 256;
  localparam int DEF_PIXEL_BITS = 8;

  // Fixed field widths.
  localparam int FUNC_W  = 3;
  localparam int PIX_W   = 8;
  localparam int CFG_W   = 9;
  localparam int SUM_W   = 24;
  localparam int VALUE_W = 25;

  // Internal widths: signed coordinates and the shared accumulator.
  localparam int COORD_W = 12;
  localparam int ACC_W   = 27;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'd1;

  // Reset value of both size registers.
  localparam logic [CFG_W-1:0] SIZE_RESET = 9'd256;

  // Function codes of an input beat.
  localparam logic [FUNC_W-1:0] FN_LOAD   = 3'd0;
  localparam logic [FUNC_W-1:0] FN_CELL   = 3'd1;
  localparam logic [FUNC_W-1:0] FN_RECT   = 3'd2;
  localparam logic [FUNC_W-1:0] FN_HAAR_X = 3'd3;
  localparam logic [FUNC_W-1:0] FN_HAAR_Y = 3'd4;

  localparam logic signed [COORD_W-1:0] COORD_ONE  = 12'sd1;
  localparam logic signed [COORD_W-1:0] COORD_NEG1 = -12'sd1;

  // Zero-extends an unsigned 9-bit field into a signed coordinate.
  function automatic logic signed [COORD_W-1:0] ext_coord(input logic [CFG_W-1:0] v);
    return $signed({{(COORD_W-CFG_W){1'b0}}, v});
  endfunction

endpackage
`default_nettype wire

@@ hdl/iibq_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// iibq_ram: generic RAM with one write port and two registered read ports
// Each read port captures the addressed word when its enable is high and
// holds the last word otherwise.
// ----------------------------------------------------------------------------
module iibq_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 65536
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re0,
  input  wire logic [$clog2(DEPTH)-1:0] raddr0,
  output logic      [WIDTH-1:0]         rdata0,
  input  wire logic                     re1,
  input  wire logic [$clog2(DEPTH)-1:0] raddr1,
  output logic      [WIDTH-1:0]         rdata1
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re0) begin
      rdata0 <= mem[raddr0];
    end
    if (re1) begin
      rdata1 <= mem[raddr1];
    end
  end

endmodule
`default_nettype wire

@@ hdl/integral_image_box_query.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// integral_image_box_query: summed area table with box and Haar queries
// Builds a summed area table from raster-order pixels and answers cell,
// clipped rectangle sum and horizontal or vertical Haar box queries.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake            Payload
//   -------   ---------  -------------------  ------------------------------------
//   in_       input      in_valid / in_stall  func, pixel, row, col, rect_width,
//                                             rect_height, box_size
//   out_      output     out_valid/out_stall  value (25-bit signed)
//   cfg_      input      cfg_valid/cfg_ready  cfg_index (0 height, 1 width), data
//
// A pixel load does one table read of the entry above, then one write. A
// cell or rectangle query walks the four corners of its rectangle, and a Haar
// query those of both its rectangles, through the two read ports of the table
// memory and folds them into one shared add/subtract unit. Unused function
// codes are dropped. Reset is synchronous and clears the load position, row
// running sum and handshake state and sets both sizes to 256; the table
// itself is not cleared. A result waits in the output register while
// out_stall is high, and the next input beat is still taken.
//
module integral_image_box_query
  import iibq_pkg::*;
#(
  parameter int MAX_ROWS   = DEF_MAX_ROWS,
  parameter int MAX_COLS   = DEF_MAX_COLS,
  parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  // Input channel.
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [FUNC_W-1:0]           in_func,
  input  wire logic [PIX_W-1:0]            in_pixel,
  input  wire logic [CFG_W-1:0]            in_row,
  input  wire logic [CFG_W-1:0]            in_col,
  input  wire logic [CFG_W-1:0]            in_rect_width,
  input  wire logic [CFG_W-1:0]            in_rect_height,
  input  wire logic [CFG_W-1:0]            in_box_size,
  // Result channel.
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic signed [VALUE_W-1:0]        out_value,
  // Configuration channel.
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [CFG_W-1:0]            cfg_data
);

  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW    = $clog2(DEPTH);
  localparam int RIW   = $clog2(MAX_ROWS);
  localparam int CIW   = $clog2(MAX_COLS);

  // Only the low PIXEL_BITS bits of a pixel take part in the sums.
  localparam logic [PIX_W-1:0] PIX_MASK =
    (PIXEL_BITS >= PIX_W) ? {PIX_W{1'b1}} : PIX_W'((1 << PIXEL_BITS) - 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_LD_RD,
    S_LD_WR,
    S_PARAM,
    S_CORNER,
    S_RD0,
    S_RD1,
    S_ADD_C,
    S_ADD_D,
    S_COMB,
    S_DONE
  } state_t;

  // Table address of a cell; both coordinates lie inside the table when used.
  function automatic logic [AW-1:0] cell_addr(input logic [COORD_W-1:0] r,
                                              input logic [COORD_W-1:0] c);
    return AW'(r[RIW-1:0]) * AW'(MAX_COLS) + AW'(c[CIW-1:0]);
  endfunction

  // Control state.
  state_t           state_r, state_nxt;
  logic [CFG_W-1:0] img_h_r, img_h_nxt;
  logic [CFG_W-1:0] img_w_r, img_w_nxt;
  logic [RIW-1:0]   load_row_r, load_row_nxt;
  logic [CIW-1:0]   load_col_r, load_col_nxt;
  logic [SUM_W-1:0] rs_r, rs_nxt;
  logic             sel_r, sel_nxt;
  logic             out_valid_r, out_valid_nxt;

  // Latched beat and working registers.
  logic [FUNC_W-1:0]         func_r, func_nxt;
  logic [PIX_W-1:0]          px_r, px_nxt;
  logic [CFG_W-1:0]          row_r, row_nxt;
  logic [CFG_W-1:0]          col_r, col_nxt;
  logic [CFG_W-1:0]          rw_r, rw_nxt;
  logic [CFG_W-1:0]          rh_r, rh_nxt;
  logic [CFG_W-1:0]          sz_r, sz_nxt;
  logic signed [COORD_W-1:0] p_row_r, p_row_nxt;
  logic signed [COORD_W-1:0] p_col_r, p_col_nxt;
  logic signed [COORD_W-1:0] p_w_r, p_w_nxt;
  logic signed [COORD_W-1:0] p_h_r, p_h_nxt;
  logic signed [COORD_W-1:0] tr_r, tr_nxt;
  logic signed [COORD_W-1:0] tc_r, tc_nxt;
  logic signed [COORD_W-1:0] br_r, br_nxt;
  logic signed [COORD_W-1:0] bc_r, bc_nxt;
  logic signed [ACC_W-1:0]   acc_r, acc_nxt;
  logic signed [ACC_W-1:0]   tot_r, tot_nxt;
  logic signed [VALUE_W-1:0] out_value_r, out_value_nxt;

  // Effective image size, saturated to 1..MAX.
  logic [CFG_W-1:0]          eff_h, eff_w;
  logic signed [COORD_W-1:0] eff_h_s, eff_w_s;

  // Shared add/subtract unit.
  logic signed [ACC_W-1:0] add_x, add_y, add_res;
  logic                    add_sub;

  // Table memory ports.
  logic             ram_we, ram_re0, ram_re1;
  logic [AW-1:0]    ram_waddr, ram_raddr0, ram_raddr1;
  logic [SUM_W-1:0] ram_wdata, ram_rdata0, ram_rdata1;

  // Corner validity: a corner with a negative coordinate reads as zero.
  logic va, vb, vc, vd;
  logic signed [ACC_W-1:0] rd0_ext, rd1_ext;

  // Scratch values.
  logic [CFG_W-1:0]          half;
  logic signed [COORD_W-1:0] bot_row, bot_col;
  logic signed [ACC_W-1:0]   rect_pos;
  logic                      last_rect;
  logic                      out_free;

  assign eff_h = (img_h_r == '0) ? CFG_W'(1) :
                 ((int'(img_h_r) > MAX_ROWS) ? CFG_W'(MAX_ROWS) : img_h_r);
  assign eff_w = (img_w_r == '0) ? CFG_W'(1) :
                 ((int'(img_w_r) > MAX_COLS) ? CFG_W'(MAX_COLS) : img_w_r);
  assign eff_h_s = ext_coord(eff_h);
  assign eff_w_s = ext_coord(eff_w);

  assign add_res = add_sub ? (add_x - add_y) : (add_x + add_y);

  assign va = !tr_r[COORD_W-1] && !tc_r[COORD_W-1];
  assign vb = !tr_r[COORD_W-1] && !bc_r[COORD_W-1];
  assign vc = !br_r[COORD_W-1] && !bc_r[COORD_W-1];
  assign vd = !br_r[COORD_W-1] && !tc_r[COORD_W-1];

  assign rd0_ext = $signed(ACC_W'(ram_rdata0));
  assign rd1_ext = $signed(ACC_W'(ram_rdata1));

  assign half      = {1'b0, sz_r[CFG_W-1:1]};
  assign bot_row   = p_row_r + p_h_r;
  assign bot_col   = p_col_r + p_w_r;
  assign rect_pos  = acc_r[ACC_W-1] ? '0 : acc_r;
  assign last_rect = (func_r == FN_HAAR_X || func_r == FN_HAAR_Y) ? sel_r : 1'b1;
  assign out_free  = !out_valid_r || !out_stall;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_value = out_value_r;
  assign cfg_ready = 1'b1;

  iibq_ram #(
    .WIDTH (SUM_W),
    .DEPTH (DEPTH)
  ) u_table (
    .clk    (clk),
    .we     (ram_we),
    .waddr  (ram_waddr),
    .wdata  (ram_wdata),
    .re0    (ram_re0),
    .raddr0 (ram_raddr0),
    .rdata0 (ram_rdata0),
    .re1    (ram_re1),
    .raddr1 (ram_raddr1),
    .rdata1 (ram_rdata1)
  );

  always_comb begin
    state_nxt     = state_r;
    img_h_nxt     = img_h_r;
    img_w_nxt     = img_w_r;
    load_row_nxt  = load_row_r;
    load_col_nxt  = load_col_r;
    rs_nxt        = rs_r;
    sel_nxt       = sel_r;
    func_nxt      = func_r;
    px_nxt        = px_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    rw_nxt        = rw_r;
    rh_nxt        = rh_r;
    sz_nxt        = sz_r;
    p_row_nxt     = p_row_r;
    p_col_nxt     = p_col_r;
    p_w_nxt       = p_w_r;
    p_h_nxt       = p_h_r;
    tr_nxt        = tr_r;
    tc_nxt        = tc_r;
    br_nxt        = br_r;
    bc_nxt        = bc_r;
    acc_nxt       = acc_r;
    tot_nxt       = tot_r;
    out_value_nxt = out_value_r;
    out_valid_nxt = out_valid_r && out_stall;

    add_x   = '0;
    add_y   = '0;
    add_sub = 1'b0;

    ram_we     = 1'b0;
    ram_waddr  = cell_addr(COORD_W'(load_row_r), COORD_W'(load_col_r));
    ram_wdata  = add_res[SUM_W-1:0];
    ram_re0    = 1'b0;
    ram_re1    = 1'b0;
    ram_raddr0 = cell_addr(tr_r, tc_r);
    ram_raddr1 = cell_addr(tr_r, bc_r);

    // Size registers are to be written between items; the block does not enforce it.
    if (cfg_valid) begin
      case (cfg_index)
        REG_IMAGE_HEIGHT: img_h_nxt = cfg_data;
        REG_IMAGE_WIDTH:  img_w_nxt = cfg_data;
        default: ;
      endcase
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          func_nxt = in_func;
          px_nxt   = in_pixel & PIX_MASK;
          row_nxt  = in_row;
          col_nxt  = in_col;
          rw_nxt   = in_rect_width;
          rh_nxt   = in_rect_height;
          sz_nxt   = in_box_size;
          sel_nxt  = 1'b0;
          case (in_func)
            FN_LOAD: state_nxt = S_LD_RD;
            FN_CELL, FN_RECT, FN_HAAR_X, FN_HAAR_Y: state_nxt = S_PARAM;
            default: state_nxt = S_IDLE;
          endcase
        end
      end

      // Add the pixel to the row running sum and fetch the entry above.
      S_LD_RD: begin
        add_x      = $signed(ACC_W'(rs_r));
        add_y      = $signed(ACC_W'(px_r));
        rs_nxt     = add_res[SUM_W-1:0];
        ram_re0    = (load_row_r != '0);
        ram_raddr0 = cell_addr(COORD_W'(RIW'(load_row_r - 1'b1)), COORD_W'(load_col_r));
        state_nxt  = S_LD_WR;
      end

      // Store running sum plus the entry above, then step the load position.
      S_LD_WR: begin
        add_x  = $signed(ACC_W'(rs_r));
        add_y  = (load_row_r != '0) ? rd0_ext : '0;
        ram_we = 1'b1;
        if (int'(load_col_r) + 1 >= int'(eff_w)) begin
          load_col_nxt = '0;
          rs_nxt       = '0;
          if (int'(load_row_r) + 1 >= int'(eff_h)) begin
            load_row_nxt = '0;
          end else begin
            load_row_nxt = RIW'(load_row_r + 1'b1);
          end
        end else begin
          load_col_nxt = CIW'(load_col_r + 1'b1);
        end
        state_nxt = S_IDLE;
      end

      // Origin and size less one of the current rectangle. The first Haar
      // rectangle is the second half, which carries the positive sign.
      S_PARAM: begin
        case (func_r)
          FN_RECT: begin
            p_row_nxt = ext_coord(row_r);
            p_col_nxt = ext_coord(col_r);
            p_w_nxt   = ext_coord(rw_r) - COORD_ONE;
            p_h_nxt   = ext_coord(rh_r) - COORD_ONE;
          end
          FN_HAAR_X: begin
            p_row_nxt = ext_coord(row_r);
            p_col_nxt = sel_r ? ext_coord(col_r) : (ext_coord(col_r) + ext_coord(half));
            p_w_nxt   = ext_coord(half) - COORD_ONE;
            p_h_nxt   = ext_coord(sz_r) - COORD_ONE;
          end
          FN_HAAR_Y: begin
            p_row_nxt = sel_r ? ext_coord(row_r) : (ext_coord(row_r) + ext_coord(half));
            p_col_nxt = ext_coord(col_r);
            p_w_nxt   = ext_coord(sz_r) - COORD_ONE;
            p_h_nxt   = ext_coord(half) - COORD_ONE;
          end
          default: begin
            p_row_nxt = ext_coord(row_r);
            p_col_nxt = ext_coord(col_r);
            p_w_nxt   = '0;
            p_h_nxt   = '0;
          end
        endcase
        state_nxt = S_CORNER;
      end

      // Clip the corners to the image. A cell read uses only the top-left
      // corner, which is marked negative when the cell lies outside.
      S_CORNER: begin
        if (func_r == FN_CELL) begin
          tr_nxt = (p_row_r < eff_h_s && p_col_r < eff_w_s) ? p_row_r : COORD_NEG1;
          tc_nxt = p_col_r;
          br_nxt = COORD_NEG1;
          bc_nxt = COORD_NEG1;
        end else begin
          tr_nxt = (p_row_r <= eff_h_s) ? (p_row_r - COORD_ONE) : COORD_NEG1;
          tc_nxt = (p_col_r <= eff_w_s) ? (p_col_r - COORD_ONE) : COORD_NEG1;
          br_nxt = (bot_row < eff_h_s) ? bot_row : (eff_h_s - COORD_ONE);
          bc_nxt = (bot_col < eff_w_s) ? bot_col : (eff_w_s - COORD_ONE);
        end
        state_nxt = S_RD0;
      end

      S_RD0: begin
        ram_re0    = 1'b1;
        ram_re1    = 1'b1;
        ram_raddr0 = cell_addr(tr_r, tc_r);
        ram_raddr1 = cell_addr(tr_r, bc_r);
        state_nxt  = S_RD1;
      end

      // Top corners are back; fetch the bottom corners meanwhile.
      S_RD1: begin
        ram_re0    = 1'b1;
        ram_re1    = 1'b1;
        ram_raddr0 = cell_addr(br_r, bc_r);
        ram_raddr1 = cell_addr(br_r, tc_r);
        add_x      = va ? rd0_ext : '0;
        add_y      = vb ? rd1_ext : '0;
        add_sub    = 1'b1;
        acc_nxt    = add_res;
        state_nxt  = S_ADD_C;
      end

      S_ADD_C: begin
        add_x     = acc_r;
        add_y     = vc ? rd0_ext : '0;
        acc_nxt   = add_res;
        state_nxt = S_ADD_D;
      end

      S_ADD_D: begin
        add_x     = acc_r;
        add_y     = vd ? rd1_ext : '0;
        add_sub   = 1'b1;
        acc_nxt   = add_res;
        state_nxt = S_COMB;
      end

      // Floor the rectangle at zero and fold it into the total.
      S_COMB: begin
        add_x   = sel_r ? tot_r : '0;
        add_y   = rect_pos;
        add_sub = sel_r;
        tot_nxt = add_res;
        if (last_rect) begin
          state_nxt = S_DONE;
        end else begin
          sel_nxt   = 1'b1;
          state_nxt = S_PARAM;
        end
      end

      S_DONE: begin
        if (out_free) begin
          out_value_nxt = tot_r[VALUE_W-1:0];
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      img_h_r     <= SIZE_RESET;
      img_w_r     <= SIZE_RESET;
      load_row_r  <= '0;
      load_col_r  <= '0;
      rs_r        <= '0;
      sel_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      img_h_r     <= img_h_nxt;
      img_w_r     <= img_w_nxt;
      load_row_r  <= load_row_nxt;
      load_col_r  <= load_col_nxt;
      rs_r        <= rs_nxt;
      sel_r       <= sel_nxt;
      out_valid_r <= out_valid_nxt;
      func_r      <= func_nxt;
      px_r        <= px_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      rw_r        <= rw_nxt;
      rh_r        <= rh_nxt;
      sz_r        <= sz_nxt;
      p_row_r     <= p_row_nxt;
      p_col_r     <= p_col_nxt;
      p_w_r       <= p_w_nxt;
      p_h_r       <= p_h_nxt;
      tr_r        <= tr_nxt;
      tc_r        <= tc_nxt;
      br_r        <= br_nxt;
      bc_r        <= bc_nxt;
      acc_r       <= acc_nxt;
      tot_r       <= tot_nxt;
      out_value_r <= out_value_nxt;
    end
  end

endmodule
`default_nettype wire
